// File: hw/rtl/ats_pkg.sv
// Shared definitions for the assembler token scanner: sizes, token kind codes,
// scan modes and byte classification helpers. No dependencies.
package ats_pkg;

  localparam int IDENT_MAX = 31;
  localparam int LEN_W     = $clog2(IDENT_MAX + 1);
  localparam int ADDR_W    = (IDENT_MAX > 1) ? $clog2(IDENT_MAX) : 1;
  localparam int VAL_W     = 64;

  localparam logic [3:0] K_IDENT  = 4'd0;
  localparam logic [3:0] K_INT    = 4'd1;
  localparam logic [3:0] K_NL     = 4'd2;
  localparam logic [3:0] K_EOF    = 4'd3;
  localparam logic [3:0] K_LBRACK = 4'd4;
  localparam logic [3:0] K_RBRACK = 4'd5;
  localparam logic [3:0] K_COMMA  = 4'd6;
  localparam logic [3:0] K_LPAREN = 4'd7;
  localparam logic [3:0] K_RPAREN = 4'd8;
  localparam logic [3:0] K_STAR   = 4'd9;
  localparam logic [3:0] K_PLUS   = 4'd10;
  localparam logic [3:0] K_MINUS  = 4'd11;
  localparam logic [3:0] K_COLON  = 4'd12;
  localparam logic [3:0] K_ERROR  = 4'd13;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_IDENT = 2'd1;
  localparam logic [1:0] MODE_INT   = 2'd2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic blank;
    logic newline;
    logic id_start;
    logic digit;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.blank    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
                 (c == 8'h0D);
    r.newline  = (c == CH_NL);
    r.id_start = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c == 8'h5F) || (c == 8'h2E);
    r.digit    = (c >= CH_ZERO && c <= 8'h39);
    return r;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      8'h5B:   k = K_LBRACK;
      8'h5D:   k = K_RBRACK;
      8'h2C:   k = K_COMMA;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h2A:   k = K_STAR;
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h3A:   k = K_COLON;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/asm_token_scanner_core.sv
// Assembler token scanner: one source byte per input word, tokens out one per
// result word. A byte that extends a pending identifier or literal, or a blank
// with nothing pending, gives no result. A byte that ends a token is accepted,
// then its results follow in order: an identifier is flushed one character per
// result, read back from the identifier buffer through its registered read
// port, one character per cycle while the output does not stall; a literal
// gives one result; then comes the closing token, if any.
// Output stall holds the sequencer. Depends on ats_pkg, ats_lit_acc.
module asm_token_scanner_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_text_byte,
  input  logic                      in_end_of_text,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_token_kind,
  output logic [ats_pkg::VAL_W-1:0] out_token_value,
  output logic                      out_token_overflow,
  output logic                      out_ident_end,
  output logic                      out_run_last
);
  import ats_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FLUSH  = 2'd1;
  localparam logic [1:0] ST_INTOUT = 2'd2;
  localparam logic [1:0] ST_TAIL   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       c_r, c_nxt;
  logic             eot_r, eot_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             fetched_r, fetched_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       kind_r, kind_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic             tovf_r, tovf_nxt;
  logic             iend_r, iend_nxt;
  logic             last_r, last_nxt;

  logic [7:0]       ident_mem [IDENT_MAX];
  logic [7:0]       mem_q_r;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  char_class_t      in_cls, tail_cls;
  logic             accept, can_push, push, tail_emits;
  logic [VAL_W-1:0] lit_next;
  logic             lit_sat;
  logic [LEN_W-1:0] idx_inc;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign can_push = !out_valid_r || !out_stall;
  assign in_cls   = classify(in_text_byte);
  assign tail_cls = classify(c_r);
  assign idx_inc  = idx_r + 1'b1;
  // closing token at end of text or when the byte is no blank and starts no token
  assign tail_emits = eot_r || !(tail_cls.blank || tail_cls.id_start || tail_cls.digit);

  ats_lit_acc u_lit (
    .acc      (acc_r),
    .digit    (in_text_byte[3:0] - CH_ZERO[3:0]),
    .acc_next (lit_next),
    .sat      (lit_sat)
  );

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    len_nxt     = len_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    c_nxt       = c_r;
    eot_nxt     = eot_r;
    idx_nxt     = idx_r;
    fetched_nxt = fetched_r;
    push        = 1'b0;
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    tovf_nxt    = tovf_r;
    iend_nxt    = iend_r;
    last_nxt    = last_r;
    mem_we      = 1'b0;
    mem_waddr   = len_r[ADDR_W-1:0];
    mem_wdata   = in_text_byte;
    mem_re      = 1'b0;
    mem_raddr   = idx_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          c_nxt   = in_text_byte;
          eot_nxt = in_end_of_text;
          if (!in_end_of_text && mode_r == MODE_IDENT &&
              (in_cls.id_start || in_cls.digit)) begin
            if (len_r < LEN_W'(IDENT_MAX)) begin
              mem_we  = 1'b1;
              len_nxt = len_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (!in_end_of_text && mode_r == MODE_INT && in_cls.digit) begin
            acc_nxt = lit_next;
            if (lit_sat) ovf_nxt = 1'b1;
          end else if (!in_end_of_text && mode_r == MODE_IDLE && in_cls.blank) begin
            state_nxt = ST_IDLE;
          end else if (mode_r == MODE_IDENT) begin
            state_nxt   = ST_FLUSH;
            idx_nxt     = '0;
            fetched_nxt = 1'b0;
          end else if (mode_r == MODE_INT) begin
            state_nxt = ST_INTOUT;
          end else begin
            state_nxt = ST_TAIL;
          end
        end
      end

      ST_FLUSH: begin
        fetched_nxt = 1'b1;
        if (fetched_r && can_push) begin
          push      = 1'b1;
          kind_nxt  = K_IDENT;
          value_nxt = {{(VAL_W-8){1'b0}}, mem_q_r};
          tovf_nxt  = ovf_r;
          iend_nxt  = (idx_inc == len_r);
          last_nxt  = (idx_inc == len_r) && !tail_emits;
          idx_nxt   = idx_inc;
          mem_raddr = idx_inc[ADDR_W-1:0];
          mem_re    = (idx_inc < len_r);
          if (idx_inc == len_r) state_nxt = ST_TAIL;
        end else begin
          mem_re = 1'b1;
        end
      end

      ST_INTOUT: begin
        if (can_push) begin
          push      = 1'b1;
          kind_nxt  = K_INT;
          value_nxt = acc_r;
          tovf_nxt  = ovf_r;
          iend_nxt  = 1'b0;
          last_nxt  = !tail_emits;
          state_nxt = ST_TAIL;
        end
      end

      ST_TAIL: begin
        if (!tail_emits || can_push) begin
          state_nxt = ST_IDLE;
          mode_nxt  = MODE_IDLE;
          len_nxt   = '0;
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          if (!eot_r && tail_cls.id_start) begin
            mode_nxt  = MODE_IDENT;
            len_nxt   = LEN_W'(1);
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = c_r;
          end else if (!eot_r && tail_cls.digit) begin
            mode_nxt = MODE_INT;
            acc_nxt  = {{(VAL_W-4){1'b0}}, c_r[3:0] - CH_ZERO[3:0]};
          end
          if (tail_emits) begin
            push      = 1'b1;
            value_nxt = '0;
            tovf_nxt  = 1'b0;
            iend_nxt  = 1'b0;
            last_nxt  = 1'b1;
            if (eot_r) begin
              kind_nxt = K_EOF;
            end else if (tail_cls.newline) begin
              kind_nxt = K_NL;
            end else begin
              kind_nxt = punct_kind(c_r);
              if (punct_kind(c_r) == K_ERROR) value_nxt = {{(VAL_W-8){1'b0}}, c_r};
            end
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (push) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // identifier buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) ident_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q_r <= ident_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_IDLE;
      len_r       <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      fetched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      fetched_r   <= fetched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    eot_r   <= eot_nxt;
    idx_r   <= idx_nxt;
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    tovf_r  <= tovf_nxt;
    iend_r  <= iend_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_token_kind     = kind_r;
  assign out_token_value    = value_r;
  assign out_token_overflow = tovf_r;
  assign out_ident_end      = iend_r;
  assign out_run_last       = last_r;

endmodule

// File: hw/rtl/ats_lit_acc.sv
// Decimal literal step: acc * 10 + digit, saturating at 2^64-1.
// Depends on ats_pkg.
module ats_lit_acc (
  input  logic [ats_pkg::VAL_W-1:0] acc,
  input  logic [3:0]                digit,
  output logic [ats_pkg::VAL_W-1:0] acc_next,
  output logic                      sat
);
  import ats_pkg::*;

  logic [VAL_W+3:0] sum;

  // acc*10 = acc*8 + acc*2, kept 4 bits wider so any carry out shows overflow
  assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VAL_W{1'b0}}, digit};
  assign sat = |sum[VAL_W+3:VAL_W];
  assign acc_next = sat ? {VAL_W{1'b1}} : sum[VAL_W-1:0];

endmodule
